FILE: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Round constants, initial hash values, controller states and commands.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_PAD2, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_byte;   // store input byte, bump count
    logic       pad_first;   // pad the current block in place
    logic       pad_second;  // zero block carrying only the length
    logic       load;        // copy chain words into a..h
    logic       round;       // one compression round
    logic       fold;        // chain += a..h
    logic       restart;     // chain and count back to initial
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       pos_last;    // next byte fills the block
    logic       len_fits;    // length fits after 0x80 in this block
    logic       last_round;
  } stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: sv/sha256_stream_hasher.sv
// A byte that fills a block holds off input while it is compressed (load, 64 rounds, fold).
// End of message: each padding block takes pad, load, 64 rounds and fold; there are two
// blocks when fewer than 9 bytes are free in the block. Then 8 digest words follow,
// one per cycle while m_tready is high. Other bytes are taken one per cycle.
// Reset (rst, synchronous) restores initial hash values and clears the count.
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming SHA-256, one byte per input word
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // msg_byte
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero pad
  output logic        m_tlast    // last_word
);
  import sha_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [2:0]  sel;
  logic [31:0] word;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_present(s_tuser), .in_end(s_tlast),
    .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_sel(sel), .stat, .cmd
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .in_byte(s_tdata), .out_sel(sel), .stat, .out_word(word)
  );

  assign m_tdata = {5'd0, sel, word};
  assign m_tlast = (sel == 3'd7);

endmodule

FILE: sv/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath: block buffer, schedule, round logic and chaining words
// One round per cycle; the block doubles as the rolling schedule window.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::cmd_t cmd,
  input  logic [7:0]    in_byte,
  input  logic [2:0]    out_sel,
  output sha_pkg::stat_t stat,
  output logic [31:0]   out_word
);
  import sha_pkg::*;

  logic [60:0] byte_count;
  logic [63:0] bit_len;
  logic [5:0]  pos;
  logic        len_fits;
  logic [31:0] chain [8];
  logic [31:0] w [16];      // w[0] is the word used by the current round
  logic [31:0] w_pad [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;

  logic [31:0] w_new, s0, s1, t1, t2, e, a;
  logic [31:0] part_word;

  assign pos      = byte_count[5:0];
  assign bit_len  = {byte_count, 3'd0};
  assign len_fits = (pos < LEN_POS);

  always_comb begin
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    w_new = s1 + w[9] + s0 + w[0];
    a  = v[0];
    e  = v[4];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & v[5]) ^ (~e & v[6])) + ROUND_K[rnd] + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  // word holding the first pad position: bytes taken so far, 0x80, zeros
  always_comb begin
    case (pos[1:0])
      2'd0: part_word = {PAD_BYTE, 24'd0};
      2'd1: part_word = {w[pos[5:2]][31:24], PAD_BYTE, 16'd0};
      2'd2: part_word = {w[pos[5:2]][31:16], PAD_BYTE, 8'd0};
      default: part_word = {w[pos[5:2]][31:8], PAD_BYTE};
    endcase
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (cmd.pad_second || 4'(i) > pos[5:2]) w_pad[i] = 32'd0;
      else if (4'(i) == pos[5:2]) w_pad[i] = part_word;
      else w_pad[i] = w[i];
    end
    if (cmd.pad_second || len_fits) begin
      w_pad[14] = bit_len[63:32];
      w_pad[15] = bit_len[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      rnd        <= '0;
      for (int j = 0; j < 8; j++) chain[j] <= INIT_H[j];
    end else begin
      if (cmd.take_byte) byte_count <= byte_count + 61'd1;
      else if (cmd.restart) byte_count <= '0;

      if (cmd.take_byte) begin
        w[pos[5:2]][{~pos[1:0], 3'd0} +: 8] <= in_byte;
      end else if (cmd.pad_first || cmd.pad_second) begin
        for (int j = 0; j < 16; j++) w[j] <= w_pad[j];
      end else if (cmd.round) begin
        for (int j = 0; j < 15; j++) w[j] <= w[j+1];
        w[15] <= w_new;
      end

      if (cmd.load) begin
        for (int j = 0; j < 8; j++) v[j] <= chain[j];
        rnd <= '0;
      end else if (cmd.round) begin
        for (int j = 1; j < 8; j++) begin
          if (j == 4) v[j] <= v[3] + t1;
          else v[j] <= v[j-1];
        end
        v[0] <= t1 + t2;
        rnd  <= rnd + 6'd1;
      end

      if (cmd.fold) begin
        for (int j = 0; j < 8; j++) chain[j] <= chain[j] + v[j];
      end else if (cmd.restart) begin
        for (int j = 0; j < 8; j++) chain[j] <= INIT_H[j];
      end
    end
  end

  assign stat.pos_last   = (pos == 6'd63);
  assign stat.len_fits   = len_fits;
  assign stat.last_round = (rnd == 6'd63);
  assign out_word        = chain[out_sel];

endmodule

FILE: sv/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer for byte intake, padding, compression and digest output
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_present,
  input  logic           in_end,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_sel,
  input  sha_pkg::stat_t stat,
  output sha_pkg::cmd_t  cmd
);
  import sha_pkg::*;

  state_t state, state_next;
  logic   ending, ending_next;       // message closes after current compress
  logic   padding, padding_next;     // compress belongs to padding
  logic   two_block, two_block_next; // length block still to come
  logic [2:0] sel, sel_next;
  logic   in_acc;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    ending_next    = ending;
    padding_next   = padding;
    two_block_next = two_block;
    sel_next       = sel;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_present && stat.pos_last) begin
            ending_next = in_end;
            state_next  = ST_LOAD;
          end else if (in_end) begin
            state_next  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        padding_next   = 1'b1;
        two_block_next = !stat.len_fits;
        state_next     = ST_LOAD;
      end
      ST_PAD2: begin
        two_block_next = 1'b0;
        state_next     = ST_LOAD;
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (stat.last_round) state_next = ST_FOLD;
      ST_FOLD: begin
        if (padding && two_block) state_next = ST_PAD2;
        else if (padding) begin
          state_next = ST_EMIT;
          sel_next   = 3'd0;
        end else if (ending) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_ready) begin
          sel_next = sel + 3'd1;
          if (sel == 3'd7) begin
            state_next   = ST_IDLE;
            ending_next  = 1'b0;
            padding_next = 1'b0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready       = (state == ST_IDLE);
    out_valid      = (state == ST_EMIT);
    cmd.take_byte  = (state == ST_IDLE) && in_valid && in_present;
    cmd.pad_first  = (state == ST_PAD);
    cmd.pad_second = (state == ST_PAD2);
    cmd.load       = (state == ST_LOAD);
    cmd.round      = (state == ST_ROUND);
    cmd.fold       = (state == ST_FOLD);
    cmd.restart    = (state == ST_EMIT) && out_ready && (sel == 3'd7);
  end
  assign out_sel = sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ending    <= 1'b0;
      padding   <= 1'b0;
      two_block <= 1'b0;
      sel       <= '0;
    end else begin
      state     <= state_next;
      ending    <= ending_next;
      padding   <= padding_next;
      two_block <= two_block_next;
      sel       <= sel_next;
    end
  end

endmodule

FILE: sv/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker: port-level checks for the SHA-256 stream hasher
// ----------------------------------------------------------------------------
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready)) else $error("input taken during digest");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7))) else $error("tlast index");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
    else $error("digest word order");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("stalled word changed");
endmodule

bind sha256_stream_hasher sha_checker u_chk (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sha256_stream_hasher
// Streams random and directed messages, predicts each digest with an
// independent SHA-256 model and checks every digest word in order.
// ----------------------------------------------------------------------------
class digest_scoreboard;
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [60:0] nbytes;
  logic [39:0] pending [$];
  logic        pending_last [$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = sha_pkg::INIT_H[i];
    nbytes = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function void note_input(logic [7:0] b, logic present, logic eom);
    int pos;
    logic [63:0] bits;
    if (present) begin
      pos = nbytes[5:0];
      blk[pos] = b;
      nbytes = nbytes + 1'b1;
      if (pos == 63) compress();
    end
    if (!eom) return;
    bits = {nbytes, 3'b000};
    pos = nbytes[5:0];
    blk[pos] = sha_pkg::PAD_BYTE;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk[pos] = 8'h00;
        pos++;
      end
      compress();
      pos = 0;
    end
    while (pos < 56) begin
      blk[pos] = 8'h00;
      pos++;
    end
    for (int j = 0; j < 8; j++) blk[63-j] = bits[8*j +: 8];
    compress();
    for (int j = 0; j < 8; j++) begin
      pending.push_back({5'd0, 3'(j), chain[j]});
      pending_last.push_back(j == 7);
    end
    restart();
  endfunction

  function void check_word(logic [39:0] data, logic last);
    logic [39:0] exp_data;
    logic exp_last;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected digest word %h last %b", data, last);
      return;
    end
    exp_data = pending.pop_front();
    exp_last = pending_last.pop_front();
    if (data !== exp_data || last !== exp_last) begin
      errors++;
      if (errors <= 10)
        $display("digest mismatch: exp %h/%b got %h/%b", exp_data, exp_last, data, last);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // msg_byte
  logic        s_tuser;   // byte_present
  logic        s_tlast;   // end_of_message
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // digest_word, word_index, zero pad
  logic        m_tlast;   // last_word

  digest_scoreboard sb;
  int idle_cycles;
  int out_wait;

  sha256_stream_hasher uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_word(logic [7:0] b, logic present, logic eom);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= present;
    s_tlast  <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(b, present, eom);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      // occasional bubble items carrying no byte
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == len - 1));
    end
    if (len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // receiver: random wait after each accepted word
  always @(posedge clk) begin
    int nw;
    if (rst) begin
      m_tready <= 1'b0;
      out_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      sb.check_word(m_tdata, m_tlast);
      nw = $urandom_range(0, 17);
      out_wait <= nw;
      m_tready <= (nw == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      m_tready <= (out_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("sha256_stream_hasher test failed");
      $finish;
    end
  end

  initial begin
    int lens [$];
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty, single bytes at extremes, pad boundaries
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    lens = '{55, 56, 64};
    foreach (lens[i]) send_message(lens[i]);
    // random short messages
    for (int n = 0; n < 4; n++)
      send_message($urandom_range(0, 12));
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("sha256_stream_hasher test passed");
    else $display("sha256_stream_hasher test failed");
    $finish;
  end
endmodule

FILE: files.f
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_ctrl.sv
sv/sha256_stream_hasher.sv
sv/sha_checker.sv
bench/tb_top.sv
